// ===== rtl/chsm_pkg.sv =====
// Shared types, constants and clamp helpers for the concrete material step.
// Used by chsm_csr, chsm_mul, chsm_div and concrete_hysteresis_material_step.
`default_nettype none

package chsm_pkg;

   // Fixed-point formats: strain Q1.30, ratios Q.30, both units shift by the same amount
   localparam int STRAIN_FRAC_BITS = 30;
   localparam int RATIO_Q          = 30;
   localparam int UNIT_SH          = STRAIN_FRAC_BITS;

   // Divider walks the dividend magnitude shifted left by UNIT_SH
   localparam int DVD_W   = 64 + UNIT_SH;
   localparam int DCNT_W  = $clog2(DVD_W);
   localparam int MUL_STEPS = 4;

   localparam logic signed [63:0] ONE_Q = 64'sd1 <<< RATIO_Q;
   localparam logic signed [63:0] TWO_Q = 64'sd2 <<< RATIO_Q;

   // Ratio polynomial coefficients, Q.30
   localparam logic signed [63:0] K145 = 64'sd155692564;
   localparam logic signed [63:0] K13  = 64'sd139586437;
   localparam logic signed [63:0] K707 = 64'sd759135470;
   localparam logic signed [63:0] K834 = 64'sd895500681;

   // Item modes
   localparam logic [1:0] MODE_EVAL   = 2'd0;
   localparam logic [1:0] MODE_COMMIT = 2'd1;
   localparam logic [1:0] MODE_INIT   = 2'd2;

   // Register map: index = paddr[5:3]
   localparam int CSR_ADDR_W = 6;
   localparam logic [2:0] REG_PEAK_STRESS     = 3'd0;
   localparam logic [2:0] REG_PEAK_STRAIN     = 3'd1;
   localparam logic [2:0] REG_ULTIMATE_STRESS = 3'd2;
   localparam logic [2:0] REG_ULTIMATE_STRAIN = 3'd3;
   localparam logic [2:0] REG_INITIAL_MODULUS = 3'd4;

   localparam logic signed [47:0] PEAK_STRESS_RST     = -48'sd1966080;
   localparam logic signed [31:0] PEAK_STRAIN_RST     = -32'sd2147484;
   localparam logic signed [47:0] ULTIMATE_STRESS_RST = -48'sd393216;
   localparam logic signed [31:0] ULTIMATE_STRAIN_RST = -32'sd4294967;
   localparam logic [46:0]        INITIAL_MODULUS_RST = 47'd983040000;

   typedef enum logic [1:0] {
      LIM_W,
      LIM_48,
      LIM_32
   } lim_type;

   typedef struct packed {
      logic signed [47:0] peak_stress;
      logic signed [31:0] peak_strain;
      logic signed [47:0] ultimate_stress;
      logic signed [31:0] ultimate_strain;
      logic [46:0]        initial_modulus;
   } cfg_type;

   typedef struct packed {
      logic               start_mul;
      logic               start_div;
      logic signed [63:0] a;
      logic signed [63:0] b;
      lim_type            lim;
   } arith_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] value;
      logic               sat;
   } arith_rsp_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               sat;
   } pack_res_type;

   function automatic logic [63:0] lim_value(lim_type lim);
      logic [63:0] l;
      case (lim)
         LIM_48:  l = 64'h0000_7FFF_FFFF_FFFF;
         LIM_32:  l = 64'h0000_0000_7FFF_FFFF;
         default: l = 64'h3FFF_FFFF_FFFF_FFFF;
      endcase
      return l;
   endfunction

   function automatic logic [63:0] mag(logic signed [63:0] x);
      logic [63:0] r;
      r = x[63] ? (64'd0 - x) : x;
      return r;
   endfunction

   // Apply sign to a magnitude, clamping to +-lim (one more on the negative side)
   function automatic pack_res_type pack(logic neg, logic over, logic [63:0] m, lim_type lim);
      logic [63:0]  l;
      pack_res_type r;
      l = lim_value(lim);
      r.sat = 1'b0;
      if (neg) begin
         if (over || m > l + 64'd1) begin
            r.value = ~l;
            r.sat   = 1'b1;
         end else begin
            r.value = 64'd0 - m;
         end
      end else if (over || m > l) begin
         r.value = l;
         r.sat   = 1'b1;
      end else begin
         r.value = m;
      end
      return r;
   endfunction

   function automatic pack_res_type clamp_val(logic signed [63:0] x, lim_type lim);
      return pack(x[63], 1'b0, mag(x), lim);
   endfunction

endpackage

`default_nettype wire

// ===== rtl/chsm_csr.sv =====
// Configuration registers behind an APB-style port.
// Depends on chsm_pkg for the register map and reset values.
`default_nettype none

module chsm_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             psel,
   input  wire logic                             penable,
   input  wire logic                             pwrite,
   input  wire logic [chsm_pkg::CSR_ADDR_W-1:0]  paddr,
   input  wire logic [63:0]                      pwdata,
   output logic      [63:0]                      prdata,
   output logic                                  pready,
   output chsm_pkg::cfg_type                     cfg
);

   chsm_pkg::cfg_type cfg_ff;
   logic              wr_en;
   logic [2:0]        idx;

   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[5:3];
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.peak_stress     <= chsm_pkg::PEAK_STRESS_RST;
         cfg_ff.peak_strain     <= chsm_pkg::PEAK_STRAIN_RST;
         cfg_ff.ultimate_stress <= chsm_pkg::ULTIMATE_STRESS_RST;
         cfg_ff.ultimate_strain <= chsm_pkg::ULTIMATE_STRAIN_RST;
         cfg_ff.initial_modulus <= chsm_pkg::INITIAL_MODULUS_RST;
      end else if (wr_en) begin
         case (idx)
            chsm_pkg::REG_PEAK_STRESS:     cfg_ff.peak_stress     <= pwdata[47:0];
            chsm_pkg::REG_PEAK_STRAIN:     cfg_ff.peak_strain     <= pwdata[31:0];
            chsm_pkg::REG_ULTIMATE_STRESS: cfg_ff.ultimate_stress <= pwdata[47:0];
            chsm_pkg::REG_ULTIMATE_STRAIN: cfg_ff.ultimate_strain <= pwdata[31:0];
            chsm_pkg::REG_INITIAL_MODULUS: cfg_ff.initial_modulus <= pwdata[46:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         chsm_pkg::REG_PEAK_STRESS:     prdata = 64'(cfg_ff.peak_stress);
         chsm_pkg::REG_PEAK_STRAIN:     prdata = 64'(cfg_ff.peak_strain);
         chsm_pkg::REG_ULTIMATE_STRESS: prdata = 64'(cfg_ff.ultimate_stress);
         chsm_pkg::REG_ULTIMATE_STRAIN: prdata = 64'(cfg_ff.ultimate_strain);
         chsm_pkg::REG_INITIAL_MODULUS: prdata = 64'(cfg_ff.initial_modulus);
         default:                       prdata = 64'd0;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/chsm_mul.sv =====
// Multi-cycle signed multiply, shift right by UNIT_SH and clamp.
// One 32x32 partial product per cycle; depends on chsm_pkg.
`default_nettype none

module chsm_mul (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire chsm_pkg::arith_req_type req,
   output chsm_pkg::arith_rsp_type      rsp
);

   logic                    busy_ff;
   logic [2:0]              step_ff;
   logic                    neg_ff;
   logic [63:0]             ua_ff;
   logic [63:0]             ub_ff;
   logic [127:0]            acc_ff;
   chsm_pkg::lim_type       lim_ff;
   chsm_pkg::arith_rsp_type rsp_ff;

   logic [31:0]  a_sel;
   logic [31:0]  b_sel;
   logic [6:0]   shamt;
   logic [63:0]  pp;
   logic [127:0] pp_sh;

   always_comb begin
      case (step_ff)
         3'd0: begin
            a_sel = ua_ff[31:0];  b_sel = ub_ff[31:0];  shamt = 7'd0;
         end
         3'd1: begin
            a_sel = ua_ff[31:0];  b_sel = ub_ff[63:32]; shamt = 7'd32;
         end
         3'd2: begin
            a_sel = ua_ff[63:32]; b_sel = ub_ff[31:0];  shamt = 7'd32;
         end
         default: begin
            a_sel = ua_ff[63:32]; b_sel = ub_ff[63:32]; shamt = 7'd64;
         end
      endcase
      pp    = a_sel * b_sel;
      pp_sh = 128'(pp) << shamt;
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         step_ff     <= 3'd0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start_mul) begin
            busy_ff <= 1'b1;
            step_ff <= 3'd0;
            neg_ff  <= req.a[63] ^ req.b[63];
            ua_ff   <= chsm_pkg::mag(req.a);
            ub_ff   <= chsm_pkg::mag(req.b);
            lim_ff  <= req.lim;
            acc_ff  <= 128'd0;
         end else if (busy_ff) begin
            if (step_ff == 3'(chsm_pkg::MUL_STEPS)) begin
               // Drop the fraction bits, flag anything above 64 bits as overflow
               {rsp_ff.value, rsp_ff.sat} <= chsm_pkg::pack(neg_ff,
                  |acc_ff[127:chsm_pkg::UNIT_SH+64],
                  acc_ff[chsm_pkg::UNIT_SH+63:chsm_pkg::UNIT_SH], lim_ff);
               rsp_ff.done <= 1'b1;
               busy_ff     <= 1'b0;
            end else begin
               acc_ff  <= acc_ff + pp_sh;
               step_ff <= step_ff + 3'd1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/chsm_div.sv =====
// Restoring divider: (|num| << UNIT_SH) / |den|, one quotient bit per cycle,
// early stop once the quotient passes the clamp. Depends on chsm_pkg.
`default_nettype none

module chsm_div (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire chsm_pkg::arith_req_type req,
   output chsm_pkg::arith_rsp_type      rsp
);

   logic                              busy_ff;
   logic [chsm_pkg::DCNT_W-1:0]       cnt_ff;
   logic [chsm_pkg::DVD_W-1:0]        dvd_ff;
   logic [63:0]                       rem_ff;
   logic [63:0]                       q_ff;
   logic [63:0]                       ud_ff;
   logic                              neg_ff;
   chsm_pkg::lim_type                 lim_ff;
   chsm_pkg::arith_rsp_type           rsp_ff;

   logic [63:0] un;
   logic [63:0] ud;
   logic [64:0] rem_sh;
   logic        ge;
   logic [64:0] rem_sub;
   logic [63:0] rem_in;
   logic [63:0] q_in;
   logic        over;

   always_comb begin
      un      = chsm_pkg::mag(req.a);
      ud      = chsm_pkg::mag(req.b);
      rem_sh  = {rem_ff, dvd_ff[chsm_pkg::DVD_W-1]};
      ge      = rem_sh >= {1'b0, ud_ff};
      rem_sub = rem_sh - {1'b0, ud_ff};
      rem_in  = ge ? rem_sub[63:0] : rem_sh[63:0];
      q_in    = {q_ff[62:0], ge};
      over    = q_in > chsm_pkg::lim_value(lim_ff) + 64'd1;
   end

   assign rsp = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         rsp_ff.done <= 1'b0;
      end else begin
         rsp_ff.done <= 1'b0;
         if (req.start_div) begin
            neg_ff <= req.a[63] ^ req.b[63];
            lim_ff <= req.lim;
            if (un == 64'd0) begin
               rsp_ff.value <= 64'sd0;
               rsp_ff.sat   <= 1'b0;
               rsp_ff.done  <= 1'b1;
            end else if (ud == 64'd0) begin
               {rsp_ff.value, rsp_ff.sat} <= chsm_pkg::pack(req.a[63] ^ req.b[63], 1'b1,
                                                            64'd0, req.lim);
               rsp_ff.done <= 1'b1;
            end else begin
               busy_ff <= 1'b1;
               dvd_ff  <= {un, {chsm_pkg::UNIT_SH{1'b0}}};
               rem_ff  <= 64'd0;
               q_ff    <= 64'd0;
               ud_ff   <= ud;
               cnt_ff  <= chsm_pkg::DCNT_W'(chsm_pkg::DVD_W - 1);
            end
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            dvd_ff <= dvd_ff << 1;
            if (over || cnt_ff == '0) begin
               {rsp_ff.value, rsp_ff.sat} <= chsm_pkg::pack(neg_ff, over, q_in, lim_ff);
               rsp_ff.done <= 1'b1;
               busy_ff     <= 1'b0;
            end else begin
               cnt_ff <= cnt_ff - 1'b1;
            end
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/concrete_hysteresis_material_step.sv =====
// Concrete material point: one strain item in, one stress/tangent item out.
// Depends on chsm_pkg, chsm_csr, chsm_mul and chsm_div.
//
// Input channel req_*: strain (Q1.30) and mode. An item is taken when req_valid
// is high and req_stall low; req_stall stays high from the item until its result
// has been handed to the output register, so one item is in work at a time.
// Result channel rsp_*: stress and tangent (Q31.16) plus a saturation flag. The
// output register holds a result while rsp_stall is high; the next item may be
// taken and worked on meanwhile, and it waits at the end for the register.
// A mode 2 (reinitialize) or repeated-strain item skips to the final state and
// its result enters the output register once free. An evaluation runs steps on
// two shared units: a multiply step is launch, four 32x32 partial products, clamp,
// handoff; a divide step launch, one quotient bit per cycle over up to 94 dividend
// bits, handoff. Reload or tension runs the line step, pure unloading the
// unloading-line step first, a new envelope point up to four divides and eight
// multiplies. The next item is taken the cycle after a result is loaded. Configuration
// goes through the APB-style port (pready always high); the user must write it
// only while no item is in work; the block does not check it. Reset (synchronous)
// loads register defaults, clears the history and drops any pending result.
`default_nettype none

module concrete_hysteresis_material_step (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic signed [31:0]              req_strain,
   input  wire logic [1:0]                      req_mode,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [47:0]                   rsp_stress,
   output logic signed [47:0]                   rsp_tangent,
   output logic                                 rsp_saturated,
   input  wire logic                            psel,
   input  wire logic                            penable,
   input  wire logic                            pwrite,
   input  wire logic [chsm_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [63:0]                     pwdata,
   output logic      [63:0]                     prdata,
   output logic                                 pready
);

   typedef enum logic [4:0] {
      S_IDLE,
      S_A1, S_A2, S_A3, S_A4,
      S_B1, S_B2,
      S_C1, S_C2, S_C3, S_C4, S_C5, S_C6, S_C7, S_C8,
      S_D1,
      S_L1,
      S_DONE
   } state_type;

   chsm_pkg::cfg_type       cfg;
   chsm_pkg::arith_req_type areq_ff;
   chsm_pkg::arith_rsp_type mul_rsp;
   chsm_pkg::arith_rsp_type div_rsp;

   state_type state_ff;
   logic      issued_ff;
   logic      commit_ff;
   logic      sat_ff;

   // Item in work
   logic signed [31:0] e_ff;
   logic signed [47:0] stress_ff;
   logic signed [47:0] k_ff;
   logic signed [63:0] t_ff;
   logic signed [63:0] t2_ff;
   logic signed [63:0] eta_ff;
   logic signed [31:0] zero_ff;
   logic signed [31:0] n_min_ff;
   logic signed [31:0] n_zero_ff;
   logic signed [47:0] n_mod_ff;

   // Committed history
   logic signed [31:0] min_ff;
   logic signed [31:0] zss_ff;
   logic signed [47:0] um_ff;
   logic signed [31:0] pstrain_ff;
   logic signed [47:0] pstress_ff;
   logic signed [47:0] ptan_ff;

   // Output register
   logic               rsp_valid_ff;
   logic signed [47:0] rsp_stress_ff;
   logic signed [47:0] rsp_tangent_ff;
   logic               rsp_saturated_ff;

   // Operand selection and result side logic
   logic                   op_div;
   logic signed [63:0]     op_a;
   logic signed [63:0]     op_b;
   chsm_pkg::lim_type      op_lim;
   logic                   res_done;
   logic signed [63:0]     res_val;
   logic                   res_sat;
   logic signed [63:0]     span;
   logic signed [63:0]     init_mod;
   chsm_pkg::pack_res_type sum_cl;
   chsm_pkg::pack_res_type ez_cl;
   logic                   out_free;
   logic                   launch;
   logic                   step_sat;

   chsm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   chsm_mul u_mul (
      .clock (clock),
      .reset (reset),
      .req   (areq_ff),
      .rsp   (mul_rsp)
   );

   chsm_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (areq_ff),
      .rsp   (div_rsp)
   );

   assign init_mod = 64'(cfg.initial_modulus);
   assign span     = 64'(e_ff) - 64'(zero_ff);
   assign res_done = mul_rsp.done | div_rsp.done;
   assign res_val  = mul_rsp.done ? mul_rsp.value : div_rsp.value;
   assign res_sat  = mul_rsp.done ? mul_rsp.sat : div_rsp.sat;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   // Launch a step once on entry to each arithmetic state
   assign launch   = !issued_ff && (state_ff != S_IDLE) && (state_ff != S_DONE);

   // Operands for the step named by the state
   always_comb begin
      op_div = 1'b0;
      op_a   = 64'sd0;
      op_b   = 64'sd0;
      op_lim = chsm_pkg::LIM_W;
      case (state_ff)
         S_A1: begin   // r = e / peak strain
            op_div = 1'b1; op_a = 64'(e_ff); op_b = 64'(cfg.peak_strain);
         end
         S_A2: begin   // q = r (2 - r)
            op_a = t_ff; op_b = chsm_pkg::TWO_Q - t_ff;
         end
         S_A3: begin
            op_a = 64'(cfg.peak_stress); op_b = t2_ff; op_lim = chsm_pkg::LIM_48;
         end
         S_A4: begin
            op_a = init_mod; op_b = chsm_pkg::ONE_Q - t_ff; op_lim = chsm_pkg::LIM_48;
         end
         S_B1: begin   // softening slope
            op_div = 1'b1;
            op_a   = 64'(cfg.ultimate_stress) - 64'(cfg.peak_stress);
            op_b   = 64'(cfg.ultimate_strain) - 64'(cfg.peak_strain);
            op_lim = chsm_pkg::LIM_48;
         end
         S_B2: begin
            op_a = 64'(k_ff); op_b = 64'(e_ff) - 64'(cfg.peak_strain);
            op_lim = chsm_pkg::LIM_48;
         end
         S_C1: begin   // eta from the strain, held at the crushing strain
            op_div = 1'b1;
            op_a   = (e_ff > cfg.ultimate_strain) ? 64'(e_ff) : 64'(cfg.ultimate_strain);
            op_b   = 64'(cfg.peak_strain);
         end
         S_C2: begin
            op_a = eta_ff; op_b = eta_ff;
         end
         S_C3: begin
            op_a = chsm_pkg::K145; op_b = t_ff;
         end
         S_C4: begin
            op_a = chsm_pkg::K13; op_b = eta_ff;
         end
         S_C5: begin
            op_a = chsm_pkg::K707; op_b = eta_ff - chsm_pkg::TWO_Q;
         end
         S_C6: begin   // zero-stress strain
            op_a = t_ff; op_b = 64'(cfg.peak_strain); op_lim = chsm_pkg::LIM_32;
         end
         S_C7: begin   // elastic span
            op_div = 1'b1; op_a = 64'(stress_ff); op_b = init_mod;
         end
         S_C8: begin   // unloading modulus
            op_div = 1'b1; op_a = 64'(stress_ff); op_b = span; op_lim = chsm_pkg::LIM_48;
         end
         S_D1: begin   // on the unloading line
            op_a = 64'(um_ff); op_b = 64'(e_ff) - 64'(zss_ff); op_lim = chsm_pkg::LIM_48;
         end
         S_L1: begin   // line from the last point
            op_a = 64'(um_ff); op_b = 64'(e_ff) - 64'(pstrain_ff);
            op_lim = chsm_pkg::LIM_48;
         end
         default: ;
      endcase
   end

   // Adds that follow a result, clamped on the way back
   always_comb begin
      if (state_ff == S_L1) begin
         sum_cl = chsm_pkg::clamp_val(64'(pstress_ff) + res_val, chsm_pkg::LIM_48);
      end else begin
         sum_cl = chsm_pkg::clamp_val(64'(cfg.peak_stress) + res_val, chsm_pkg::LIM_48);
      end
      ez_cl = chsm_pkg::clamp_val(64'(e_ff) - res_val, chsm_pkg::LIM_32);
   end

   // Saturation raised by the step that finishes now, including the clamp after it
   always_comb begin
      step_sat = res_sat;
      case (state_ff)
         S_B2, S_L1: step_sat = res_sat | sum_cl.sat;
         S_C7:       step_sat = res_sat | ((span < res_val) ? 1'b0 : ez_cl.sat);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_IDLE;
         issued_ff         <= 1'b0;
         commit_ff         <= 1'b0;
         areq_ff.start_mul <= 1'b0;
         areq_ff.start_div <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         min_ff            <= 32'sd0;
         zss_ff            <= 32'sd0;
         um_ff             <= 48'(chsm_pkg::INITIAL_MODULUS_RST);
         pstrain_ff        <= 32'sd0;
         pstress_ff        <= 48'sd0;
         ptan_ff           <= 48'sd0;
      end else begin
         areq_ff.start_mul <= launch && !op_div;
         areq_ff.start_div <= launch && op_div;
         if (state_ff == S_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  e_ff   <= req_strain;
                  sat_ff <= 1'b0;
                  if (req_mode == chsm_pkg::MODE_INIT) begin
                     // Reinitialize history from the current registers
                     commit_ff  <= 1'b0;
                     state_ff   <= S_DONE;
                     min_ff     <= 32'sd0;
                     zss_ff     <= 32'sd0;
                     um_ff      <= 48'(cfg.initial_modulus);
                     pstrain_ff <= 32'sd0;
                     pstress_ff <= 48'sd0;
                     ptan_ff    <= 48'sd0;
                     stress_ff  <= 48'sd0;
                     k_ff       <= 48'(cfg.initial_modulus);
                  end else if (req_strain == pstrain_ff) begin
                     // Repeated strain: return the stored point
                     commit_ff <= 1'b0;
                     state_ff  <= S_DONE;
                     stress_ff <= pstress_ff;
                     if (ptan_ff == 48'sd0 && req_strain == 32'sd0 && min_ff == 32'sd0) begin
                        k_ff <= 48'(cfg.initial_modulus);
                     end else begin
                        k_ff <= ptan_ff;
                     end
                  end else begin
                     commit_ff <= (req_mode == chsm_pkg::MODE_COMMIT);
                     k_ff      <= 48'sd0;
                     n_zero_ff <= zss_ff;
                     n_mod_ff  <= um_ff;
                     if (req_strain < 32'sd0 && req_strain <= min_ff) begin
                        // New point on the envelope
                        n_min_ff <= req_strain;
                        if (req_strain > cfg.peak_strain) begin
                           stress_ff <= 48'sd0;
                           state_ff  <= S_A1;
                        end else if (req_strain > cfg.ultimate_strain) begin
                           stress_ff <= 48'sd0;
                           state_ff  <= S_B1;
                        end else begin
                           stress_ff <= cfg.ultimate_stress;
                           state_ff  <= S_C1;
                        end
                     end else begin
                        n_min_ff  <= min_ff;
                        stress_ff <= 48'sd0;
                        if (req_strain < 32'sd0 && req_strain < zss_ff) begin
                           state_ff <= S_D1;
                        end else begin
                           state_ff <= S_L1;
                        end
                     end
                  end
               end
            end
            S_DONE: begin
               // Hold until the output register is free
               if (out_free) begin
                  rsp_stress_ff    <= stress_ff;
                  rsp_tangent_ff   <= k_ff;
                  rsp_saturated_ff <= sat_ff;
                  if (commit_ff) begin
                     min_ff     <= n_min_ff;
                     zss_ff     <= n_zero_ff;
                     um_ff      <= n_mod_ff;
                     pstrain_ff <= e_ff;
                     pstress_ff <= stress_ff;
                     ptan_ff    <= k_ff;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               if (!issued_ff) begin
                  // Launch this step on the shared unit
                  areq_ff.a   <= op_a;
                  areq_ff.b   <= op_b;
                  areq_ff.lim <= op_lim;
                  issued_ff   <= 1'b1;
               end else if (res_done) begin
                  issued_ff <= 1'b0;
                  sat_ff    <= sat_ff | step_sat;
                  case (state_ff)
                     S_A1: begin
                        t_ff <= res_val; state_ff <= S_A2;
                     end
                     S_A2: begin
                        t2_ff <= res_val; state_ff <= S_A3;
                     end
                     S_A3: begin
                        stress_ff <= res_val[47:0]; state_ff <= S_A4;
                     end
                     S_A4: begin
                        k_ff <= res_val[47:0]; state_ff <= S_C1;
                     end
                     S_B1: begin
                        k_ff <= res_val[47:0]; state_ff <= S_B2;
                     end
                     S_B2: begin
                        stress_ff <= sum_cl.value[47:0];
                        state_ff  <= S_C1;
                     end
                     S_C1: begin
                        eta_ff   <= res_val;
                        state_ff <= (res_val < chsm_pkg::TWO_Q) ? S_C2 : S_C5;
                     end
                     S_C2: begin
                        t_ff <= res_val; state_ff <= S_C3;
                     end
                     S_C3: begin
                        t_ff <= res_val; state_ff <= S_C4;
                     end
                     S_C4: begin
                        t_ff <= t_ff + res_val; state_ff <= S_C6;
                     end
                     S_C5: begin
                        t_ff <= res_val + chsm_pkg::K834; state_ff <= S_C6;
                     end
                     S_C6: begin
                        zero_ff <= res_val[31:0]; state_ff <= S_C7;
                     end
                     S_C7: begin
                        // Steeper than elastic: keep the polynomial intercept
                        if (span < res_val) begin
                           n_zero_ff <= zero_ff;
                           state_ff  <= S_C8;
                        end else begin
                           n_zero_ff <= ez_cl.value[31:0];
                           n_mod_ff  <= 48'(cfg.initial_modulus);
                           state_ff  <= S_L1;
                        end
                     end
                     S_C8: begin
                        n_mod_ff <= res_val[47:0]; state_ff <= S_L1;
                     end
                     S_D1: begin
                        stress_ff <= res_val[47:0];
                        k_ff      <= um_ff;
                        state_ff  <= S_L1;
                     end
                     S_L1: begin
                        // No crossing of the line through the last point
                        if (e_ff < pstrain_ff && $signed(sum_cl.value[47:0]) > stress_ff) begin
                           stress_ff <= sum_cl.value[47:0];
                           k_ff      <= um_ff;
                        end
                        state_ff <= S_DONE;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   assign req_stall     = (state_ff != S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_stress    = rsp_stress_ff;
   assign rsp_tangent   = rsp_tangent_ff;
   assign rsp_saturated = rsp_saturated_ff;

   // A unit answers only to a launched step
   assert property (@(posedge clock) disable iff (reset)
      res_done |-> issued_ff)
      else $error("arithmetic result without an outstanding step");

   // The two units never answer in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(mul_rsp.done && div_rsp.done))
      else $error("multiplier and divider finished together");

   // A new result appears only out of the final state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside the final state");

   // Nothing is launched while a step is still outstanding
   assert property (@(posedge clock) disable iff (reset)
      (areq_ff.start_mul || areq_ff.start_div) |-> $past(!issued_ff))
      else $error("second launch while a step is outstanding");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// Self-checking testbench for the concrete material step: directed table, then random
// strain walks under several register settings. Depends on chsm_pkg and the top level RTL.
`timescale 1ns / 1ps

module tb;

   localparam logic [63:0] LIM_STRESS = 64'h0000_7FFF_FFFF_FFFF;
   localparam logic [63:0] LIM_STRAIN = 64'h0000_0000_7FFF_FFFF;
   localparam logic [63:0] LIM_RATIO  = 64'h3FFF_FFFF_FFFF_FFFF;
   localparam int          ITEMS_PER_PHASE = 280;
   localparam int          SHOW_MAX = 10;

   typedef struct {
      logic signed [63:0] stress;
      logic signed [63:0] tangent;
      logic               saturated;
   } stress_point_type;

   typedef struct {
      logic signed [31:0] strain;
      logic [1:0]         mode;
      bit                 typed;
      stress_point_type   point;
   } strain_item_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic signed [31:0] req_strain;
   logic [1:0]         req_mode;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [47:0] rsp_stress;
   logic signed [47:0] rsp_tangent;
   logic               rsp_saturated;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [chsm_pkg::CSR_ADDR_W-1:0] paddr;
   logic [63:0]        pwdata;
   logic [63:0]        prdata;
   logic               pready;

   concrete_hysteresis_material_step u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_strain(req_strain), .req_mode(req_mode),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_stress(rsp_stress), .rsp_tangent(rsp_tangent), .rsp_saturated(rsp_saturated),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Material registers as the block should hold them
   logic signed [63:0] m_peak_stress, m_peak_strain, m_ult_stress, m_ult_strain, m_init_mod;
   // Committed history
   logic signed [63:0] h_min_strain, h_zero_strain, h_unload_mod;
   logic signed [63:0] h_prev_strain, h_prev_stress, h_prev_tangent;

   stress_point_type expected_points[$];
   strain_item_type  item_list[$];
   bit               clamp_hit;
   int               mismatch_count;
   int               stall_pct;
   logic signed [31:0] walk_strain;

   // ---------------------------------------------------------------- fixed point
   function automatic logic [127:0] magnitude(logic signed [63:0] x);
      logic [63:0] u;
      u = x[63] ? (64'd0 - x) : x;
      return {64'd0, u};
   endfunction

   // Sign a magnitude and clamp to +-lim; any clamp marks the item saturated
   function automatic logic signed [63:0] sign_clamp(bit neg, logic [127:0] m,
                                                     logic [63:0] lim);
      if (neg) begin
         if (m > {64'd0, lim} + 128'd1) begin
            clamp_hit = 1'b1;
            return ~lim;
         end
         return 64'd0 - m[63:0];
      end
      if (m > {64'd0, lim}) begin
         clamp_hit = 1'b1;
         return lim;
      end
      return m[63:0];
   endfunction

   function automatic logic signed [63:0] clamp_to(logic signed [63:0] x, logic [63:0] lim);
      return sign_clamp(x[63], magnitude(x), lim);
   endfunction

   // (a * b) >> 30, truncated toward zero
   function automatic logic signed [63:0] mul_q30(logic signed [63:0] a,
                                                  logic signed [63:0] b, logic [63:0] lim);
      logic [127:0] m;
      m = (magnitude(a) * magnitude(b)) >> 30;
      return sign_clamp((a[63] != b[63]) && (m != 0), m, lim);
   endfunction

   // (num << 30) / den, truncated toward zero; a zero divisor clamps
   function automatic logic signed [63:0] div_q30(logic signed [63:0] num,
                                                  logic signed [63:0] den, logic [63:0] lim);
      logic [127:0] q;
      bit           neg;
      neg = num[63] != den[63];
      if (num == 0) return 64'sd0;
      if (den == 0) return sign_clamp(neg, {128{1'b1}}, lim);
      q = (magnitude(num) << 30) / magnitude(den);
      return sign_clamp(neg && (q != 0), q, lim);
   endfunction

   task automatic clear_history();
      h_min_strain   = 0;
      h_zero_strain  = 0;
      h_unload_mod   = m_init_mod;
      h_prev_strain  = 0;
      h_prev_stress  = 0;
      h_prev_tangent = 0;
   endtask

   // Material response to one strain item; commits history on a commit item and clears it on an init item
   task automatic material_response(input logic signed [31:0] strain_in, input logic [1:0] mode,
                                    output stress_point_type res);
      logic signed [63:0] e, stress, k, line, n_min, n_zero, n_mod;
      logic signed [63:0] r, q, m, eta, ratio, zero, span, espan;
      e = strain_in;
      stress = 0;
      k = 0;
      n_min = h_min_strain;
      n_zero = h_zero_strain;
      n_mod = h_unload_mod;
      clamp_hit = 1'b0;
      if (mode == chsm_pkg::MODE_INIT) begin
         clear_history();
         res.stress = 0;
         res.tangent = m_init_mod;
         res.saturated = 1'b0;
         return;
      end
      // Same strain again: hand back the stored point untouched
      if (e == h_prev_strain) begin
         res.stress = h_prev_stress;
         res.tangent = (h_prev_tangent == 0 && e == 0 && h_min_strain == 0) ?
                       m_init_mod : h_prev_tangent;
         res.saturated = 1'b0;
         return;
      end
      if (e < 0) begin
         if (e <= h_min_strain) begin
            if (e > m_peak_strain) begin
               r = div_q30(e, m_peak_strain, LIM_RATIO);
               q = mul_q30(r, chsm_pkg::TWO_Q - r, LIM_RATIO);
               stress = mul_q30(m_peak_stress, q, LIM_STRESS);
               k = mul_q30(m_init_mod, chsm_pkg::ONE_Q - r, LIM_STRESS);
            end else if (e > m_ult_strain) begin
               k = div_q30(m_ult_stress - m_peak_stress, m_ult_strain - m_peak_strain,
                           LIM_STRESS);
               stress = clamp_to(m_peak_stress + mul_q30(k, e - m_peak_strain, LIM_STRESS),
                                 LIM_STRESS);
            end else begin
               stress = m_ult_stress;
               k = 0;
            end
            n_min = e;
            m = (e > m_ult_strain) ? e : m_ult_strain;
            eta = div_q30(m, m_peak_strain, LIM_RATIO);
            if (eta < chsm_pkg::TWO_Q)
               ratio = mul_q30(chsm_pkg::K145, mul_q30(eta, eta, LIM_RATIO), LIM_RATIO)
                     + mul_q30(chsm_pkg::K13, eta, LIM_RATIO);
            else
               ratio = mul_q30(chsm_pkg::K707, eta - chsm_pkg::TWO_Q, LIM_RATIO)
                     + chsm_pkg::K834;
            zero = mul_q30(ratio, m_peak_strain, LIM_STRAIN);
            span = e - zero;
            espan = div_q30(stress, m_init_mod, LIM_RATIO);
            if (span < espan) begin
               n_zero = zero;
               n_mod = div_q30(stress, span, LIM_STRESS);
            end else begin
               n_zero = clamp_to(e - espan, LIM_STRAIN);
               n_mod = m_init_mod;
            end
         end else if (e < h_zero_strain) begin
            stress = mul_q30(h_unload_mod, e - h_zero_strain, LIM_STRESS);
            k = h_unload_mod;
         end
      end
      // Never cross the line from the last point
      line = clamp_to(h_prev_stress + mul_q30(h_unload_mod, e - h_prev_strain, LIM_STRESS),
                      LIM_STRESS);
      if (e < h_prev_strain && line > stress) begin
         stress = line;
         k = h_unload_mod;
      end
      if (mode == chsm_pkg::MODE_COMMIT) begin
         h_min_strain = n_min;
         h_zero_strain = n_zero;
         h_unload_mod = n_mod;
         h_prev_strain = e;
         h_prev_stress = stress;
         h_prev_tangent = k;
      end
      res.stress = stress;
      res.tangent = k;
      res.saturated = clamp_hit;
   endtask

   // ---------------------------------------------------------------- clock, limit
   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- register port
   task automatic write_reg(input logic [2:0] index, input logic [63:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 3'b000};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         chsm_pkg::REG_PEAK_STRESS:     m_peak_stress = $signed(value[47:0]);
         chsm_pkg::REG_PEAK_STRAIN:     m_peak_strain = $signed(value[31:0]);
         chsm_pkg::REG_ULTIMATE_STRESS: m_ult_stress  = $signed(value[47:0]);
         chsm_pkg::REG_ULTIMATE_STRAIN: m_ult_strain  = $signed(value[31:0]);
         default:                       m_init_mod    = {17'd0, value[46:0]};
      endcase
   endtask

   task automatic load_material(input logic signed [63:0] ps, input logic signed [63:0] pe,
                                input logic signed [63:0] us, input logic signed [63:0] ue,
                                input logic [63:0] im);
      write_reg(chsm_pkg::REG_PEAK_STRESS, ps);
      write_reg(chsm_pkg::REG_PEAK_STRAIN, pe);
      write_reg(chsm_pkg::REG_ULTIMATE_STRESS, us);
      write_reg(chsm_pkg::REG_ULTIMATE_STRAIN, ue);
      write_reg(chsm_pkg::REG_INITIAL_MODULUS, im);
   endtask

   // Plausible material: peak strain, softening to a lower crushing strain,
   // modulus as twice peak stress over peak strain
   task automatic load_random_material();
      logic [63:0] pe, ps;
      pe = $urandom_range(1 << 24, 1 << 19);
      ps = $urandom_range(1 << 25, 1 << 14);
      load_material(-$signed(ps), -$signed(pe), -$signed(ps / $urandom_range(8, 2)),
                    -$signed(pe * $urandom_range(5, 2)), ((ps << 31) / pe) | 64'd1);
   endtask

   // Wait for every result, then let the block settle before touching registers
   task automatic drain();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic add_item(input strain_item_type it);
      item_list = {item_list, it};
   endtask

   // ---------------------------------------------------------------- sender
   task automatic send_items();
      int               burst;
      int               gap;
      strain_item_type  it;
      stress_point_type pt;
      burst = 0;
      while (item_list.size() != 0) begin
         it = item_list.pop_front();
         if (burst == 0) begin
            req_valid <= 1'b0;
            gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
            repeat (gap) @(posedge clock);
            burst = $urandom_range(16, 1);
         end
         req_valid <= 1'b1;
         req_strain <= it.strain;
         req_mode <= it.mode;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         material_response(it.strain, it.mode, pt);
         if (it.typed) pt = it.point;
         expected_points = {expected_points, pt};
         burst--;
      end
      req_valid <= 1'b0;
   endtask

   function automatic strain_item_type make_item(logic signed [31:0] s, logic [1:0] md);
      strain_item_type it;
      it.strain = s;
      it.mode = md;
      it.typed = 1'b0;
      it.point = '{0, 0, 1'b0};
      return it;
   endfunction

   function automatic strain_item_type typed_item(logic signed [31:0] s, logic [1:0] md,
                                                  logic signed [63:0] st,
                                                  logic signed [63:0] tg);
      strain_item_type it;
      it = make_item(s, md);
      it.typed = 1'b1;
      it.point = '{st, tg, 1'b0};
      return it;
   endfunction

   // Mostly committed walks around the envelope, some noise and resets
   task automatic queue_random(input int count);
      int          pick;
      logic [31:0] scale;
      logic [31:0] step;
      scale = 32'(magnitude(m_peak_strain));
      if (scale < 1024) scale = 1024;
      if (scale > 32'h2000_0000) scale = 32'h2000_0000;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99, 0);
         if (pick < 72) begin
            step = $urandom_range(scale / 2, 0);
            if ($urandom_range(9, 0) < 6) walk_strain = walk_strain - $signed(step);
            else walk_strain = walk_strain + $signed(step);
            if (walk_strain > $signed(scale)) walk_strain = $signed(scale);
            add_item(make_item(walk_strain, ($urandom_range(4, 0) == 0) ?
                               chsm_pkg::MODE_EVAL : chsm_pkg::MODE_COMMIT));
         end else if (pick < 82) begin
            add_item(make_item(walk_strain, 2'($urandom_range(1, 0))));
         end else if (pick < 86) begin
            walk_strain = 0;
            add_item(make_item(0, chsm_pkg::MODE_INIT));
         end else if (pick < 89) begin
            add_item(make_item($urandom, 2'd3));
         end else begin
            walk_strain = $urandom;
            add_item(make_item(walk_strain, 2'($urandom_range(1, 0))));
         end
      end
   endtask

   // ---------------------------------------------------------------- receiver
   always @(posedge clock) begin
      stress_point_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= SHOW_MAX)
                  $display("tb: unexpected item stress=%0d tangent=%0d", rsp_stress, rsp_tangent);
            end else begin
               want = expected_points.pop_front();
               if (rsp_stress !== want.stress[47:0] || rsp_tangent !== want.tangent[47:0] ||
                   rsp_saturated !== want.saturated) begin
                  mismatch_count++;
                  if (mismatch_count <= SHOW_MAX)
                     $display("tb: mismatch exp %0d/%0d/%0b got %0d/%0d/%0b",
                              $signed(want.stress[47:0]), $signed(want.tangent[47:0]),
                              want.saturated, rsp_stress, rsp_tangent, rsp_saturated);
               end
            end
         end
         rsp_stall <= ($urandom_range(99, 0) < stall_pct);
      end
   end

   // Receiver stall pattern: swap between calm, light and heavy stretches
   always @(posedge clock) begin
      if ($urandom_range(299, 0) == 0) stall_pct <= $urandom_range(2, 0) * 35;
   end

   // ---------------------------------------------------------------- main sequence
   initial begin
      req_valid = 1'b0;
      req_strain = 0;
      req_mode = chsm_pkg::MODE_EVAL;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      walk_strain = 0;
      m_peak_stress = chsm_pkg::PEAK_STRESS_RST;
      m_peak_strain = chsm_pkg::PEAK_STRAIN_RST;
      m_ult_stress = chsm_pkg::ULTIMATE_STRESS_RST;
      m_ult_strain = chsm_pkg::ULTIMATE_STRAIN_RST;
      m_init_mod = {17'd0, chsm_pkg::INITIAL_MODULUS_RST};
      clear_history();
      reset = 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      // Directed walk under the reset material: repeat at zero, init, rising
      // envelope, peak, softening, repeat, unload, reload, tension, plateau, the
      // unused mode, range ends, init again
      add_item(typed_item(0, chsm_pkg::MODE_EVAL, 0, chsm_pkg::INITIAL_MODULUS_RST));
      add_item(typed_item(0, chsm_pkg::MODE_INIT, 0, chsm_pkg::INITIAL_MODULUS_RST));
      add_item(make_item(-1, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-1000000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-2147484, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-3000000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-3000000, chsm_pkg::MODE_EVAL));
      add_item(make_item(-2000000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-2500000, chsm_pkg::MODE_EVAL));
      add_item(make_item(-2600000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(1000000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-6000000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(-7000000, 2'd3));
      add_item(make_item(32'sh8000_0000, chsm_pkg::MODE_COMMIT));
      add_item(make_item(32'sh7FFF_FFFF, chsm_pkg::MODE_COMMIT));
      add_item(make_item(32'sh7FFF_FFFF, chsm_pkg::MODE_EVAL));
      add_item(typed_item(-5, chsm_pkg::MODE_INIT, 0, chsm_pkg::INITIAL_MODULUS_RST));
      add_item(typed_item(0, chsm_pkg::MODE_EVAL, 0, chsm_pkg::INITIAL_MODULUS_RST));
      send_items();
      queue_random(ITEMS_PER_PHASE / 2);
      send_items();
      // Hold off until the block has emptied, then carry on
      while (expected_points.size() != 0) @(posedge clock);
      queue_random(ITEMS_PER_PHASE / 2);
      send_items();
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: load_material(-64'sh8000_0000_0000, -64'sh8000_0000, 0, -2,
                             64'h7FFF_FFFF_FFFF);
            1: load_material(-1, -1, -1, -64'sh8000_0000, 1);
            default: load_random_material();
         endcase
         walk_strain = 0;
         add_item(make_item(0, chsm_pkg::MODE_INIT));
         queue_random(ITEMS_PER_PHASE);
         send_items();
         drain();
      end

      if (mismatch_count == 0 && expected_points.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
